### rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test block.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int WIDTH    = 32;
   localparam int CAND_W   = 32;
   localparam int SQ_W     = WIDTH + 2;
   localparam int CNT_W    = $clog2(WIDTH);
   localparam int FIRST_D  = 3;
   localparam int FIRST_SQ = FIRST_D * FIRST_D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_TEST
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic next_div;
   } cmd_type;

   typedef struct packed {
      logic lt2;
      logic eq2;
      logic even;
      logic bound_ok;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

`default_nettype wire

### rtl/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Tests one unsigned candidate per item and returns a prime flag.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Values below two, even values and odd
// values below nine take their flag from the first check state. Any other
// odd candidate takes, for each odd trial divisor, a bound check against
// the running square, WIDTH steps of the bit-serial remainder unit and a
// zero test. The result sits in an output register, so a new item is taken
// as soon as the sequencer returns to idle even while the last flag waits.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
   import tdpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CAND_W-1:0] req_candidate,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_prime_flag
);

   cmd_type    cmd;
   status_type status;
   logic       busy;

   tdpt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag),
      .status         (status),
      .cmd            (cmd),
      .busy           (busy)
   );

   tdpt_datapath u_datapath (
      .clock     (clock),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.next_div}))
      else $error("more than one datapath command at once");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> busy)
      else $error("sequencer not busy after taking an item");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("result raised without an item in work");

endmodule

`default_nettype wire

### rtl/tdpt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate, trial divisor, running square and bit-serial remainder unit.
// ----------------------------------------------------------------------------
module tdpt_datapath
   import tdpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [CAND_W-1:0] candidate,
   input  wire cmd_type           cmd,
   output status_type             status
);

   logic [WIDTH-1:0] n_ff,     n_in;
   logic [WIDTH-1:0] d_ff,     d_in;
   logic [SQ_W-1:0]  sq_ff,    sq_in;
   logic [WIDTH-1:0] rem_ff,   rem_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   rem_sub;

   assign rem_shift = {rem_ff, shift_ff[WIDTH-1]};
   assign rem_sub   = rem_shift - {1'b0, d_ff};

   always_comb begin
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         n_in  = WIDTH'(candidate);
         d_in  = WIDTH'(FIRST_D);
         sq_in = SQ_W'(FIRST_SQ);
      end
      if (cmd.div_start) begin
         rem_in   = '0;
         shift_in = n_ff;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, d_ff}) begin
            rem_in = rem_sub[WIDTH-1:0];
         end else begin
            rem_in = rem_shift[WIDTH-1:0];
         end
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      // (d+2)^2 = d^2 + 4d + 4
      if (cmd.next_div) begin
         d_in  = d_ff + WIDTH'(2);
         sq_in = sq_ff + {d_ff, 2'b00} + SQ_W'(4);
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      status.lt2      = (n_ff < WIDTH'(2));
      status.eq2      = (n_ff == WIDTH'(2));
      status.even     = ~n_ff[0];
      status.bound_ok = (sq_ff <= SQ_W'(n_ff));
      status.div_last = (cnt_ff == CNT_W'(WIDTH - 1));
      status.rem_zero = (rem_ff == '0);
   end

endmodule

`default_nettype wire

### rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial loop and the registered result stage.
// ----------------------------------------------------------------------------
module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_prime_flag,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      flag_ff, flag_in;
   logic      out_free;

   assign out_free       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall      = (state_ff != ST_IDLE);
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      flag_in      = flag_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.lt2 | status.even | ~status.bound_ok) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  flag_in      = status.eq2 |
                                 (~status.lt2 & ~status.even & ~status.bound_ok);
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.rem_zero) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  flag_in      = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### verif/trial_division_prime_test_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_top_test
// Self-checking bench for the trial division prime test block.
// A queue of pending candidates feeds a clocked driver. Each accepted item
// gets a prime flag predicted by plain trial division, and the block's
// results are checked in order against it. Three idling mixes are run on
// the two channels: receiver slow, then sender slow, then neither idle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top_test
   import tdpt_pkg::*;
;

   localparam int CLK_HALF     = 5;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_EVERY  = 40;
   localparam int TAIL_CYCLES  = 50;

   typedef struct {
      logic [CAND_W-1:0] candidate;
      bit                drain_first;
   } pending_item_type;

   typedef struct {
      logic [CAND_W-1:0] candidate;
      bit                prime_flag;
   } flag_due_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [CAND_W-1:0] req_candidate = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_prime_flag;

   pending_item_type candidates_pending[$];
   flag_due_type     prime_flags_due[$];
   bit               req_taken = 1'b0;
   int               total_items = 1;
   int               directed_items;
   int               items_sent;
   int               flags_seen;
   int               primes_seen;
   int               failures;
   int               cycles;
   int               send_idle_pct;
   int               recv_idle_pct;

   trial_division_prime_test_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_candidate  (req_candidate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag)
   );

   always #CLK_HALF clock = ~clock;

   function automatic bit predict_prime(logic [CAND_W-1:0] raw);
      longint unsigned n;
      longint unsigned d;
      n = raw;
      if (WIDTH < 64) n = n & ((64'd1 << WIDTH) - 1);
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if ((n & 1) == 0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         case (items_sent * 3 / total_items)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (!req_valid || req_taken) begin
            if (candidates_pending.size() != 0 &&
                !(candidates_pending[0].drain_first && prime_flags_due.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_candidate <= candidates_pending[0].candidate;
               void'(candidates_pending.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: handshakes sampled on the rising edge
   always @(posedge clock) begin
      flag_due_type due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (prime_flags_due.size() == 0) begin
               $error("unexpected item: prime_flag actual %0b", rsp_prime_flag);
               failures++;
            end else begin
               due = prime_flags_due.pop_front();
               if (rsp_prime_flag !== due.prime_flag) begin
                  $error("prime_flag mismatch for candidate %0d: expected %0b, actual %0b",
                         due.candidate, due.prime_flag, rsp_prime_flag);
                  failures++;
               end
               flags_seen++;
               if (due.prime_flag) primes_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            prime_flags_due.push_back('{req_candidate, predict_prime(req_candidate)});
            items_sent++;
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [CAND_W-1:0] directed_values[] = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9,
         32'd15, 32'd25, 32'd49, 32'd97, 32'd121, 32'd16777213, 32'd16752649,
         32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
         32'h5555_5555, 32'hAAAA_AAAA
      };
      int unsigned       small_factors[4] = '{2, 3, 5, 7};
      logic [CAND_W-1:0] cand;
      int unsigned       factor;
      int                sel;

      foreach (directed_values[k])
         candidates_pending.push_back('{directed_values[k], k == 14});
      directed_items = candidates_pending.size();

      // mostly small values, a few wide ones with a small factor to keep runs short
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            cand = $urandom_range(0, 4095);
         end else if (sel < 7) begin
            cand = $urandom_range(4096, 65535);
         end else if (sel < 8) begin
            cand = $urandom_range(65536, 1 << 20);
         end else begin
            factor = small_factors[$urandom_range(0, 3)];
            cand   = $urandom;
            cand   = cand - cand % factor;
         end
         candidates_pending.push_back('{cand, (i % DRAIN_EVERY) == 0});
      end
      total_items = candidates_pending.size();

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (candidates_pending.size() != 0 || req_valid) @(posedge clock);
      while (prime_flags_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d of %0d candidates (%0d directed, rest random), %0d prime",
               flags_seen, items_sent, directed_items, primes_seen);
      $display("idling mixes: sender 36/receiver 64, sender 64/receiver 36, none");
      if (failures == 0 && prime_flags_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/tdpt_pkg.sv
rtl/tdpt_datapath.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_prime_test_top.sv
verif/trial_division_prime_test_top_test.sv
